[rtl/core/sound_chip_state_variable_filter_defines.svh]
// Assertion macros used by the filter's top-level RTL file.
`ifndef SOUND_CHIP_STATE_VARIABLE_FILTER_DEFINES_SVH
`define SOUND_CHIP_STATE_VARIABLE_FILTER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SC_SVF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sc_svf assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SC_SVF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sc_svf assertion failed");

`endif

[rtl/core/sc_svf_pkg.sv]
// Package with the filter's types, widths and fixed constants.
`default_nettype none
package sc_svf_pkg;

    localparam int DATA_W     = 32;
    localparam int SAMPLE_W   = 20;
    localparam int SUM_W      = 22;
    localparam int CYC_W      = 8;
    localparam int CUT_W      = 15;
    localparam int RES_W      = 11;
    localparam int ROUTE_W    = 4;
    localparam int MODE_W     = 3;
    localparam int VOL_W      = 4;
    localparam int OFS_W      = 10;
    localparam int CFG_DATA_W = 15;
    localparam int N_SRC      = 4;

    localparam int WDT_SHIFT = 6;
    localparam int BP_SHIFT  = 14;
    localparam int Q_SHIFT   = 10;

    localparam logic [1:0]       VOICE3_SLOT = 2'd2;
    localparam logic [1:0]       LAST_SLOT   = 2'd3;
    localparam logic [RES_W-1:0] RES_RESET   = 11'd1448;

    localparam int MODE_LP = 0;
    localparam int MODE_BP = 1;
    localparam int MODE_HP = 2;

    typedef enum logic [2:0] {
        CFG_FILTER_ENABLE,
        CFG_CUTOFF,
        CFG_RESONANCE,
        CFG_ROUTE,
        CFG_MUTE,
        CFG_MODE,
        CFG_VOLUME,
        CFG_OFFSET
    } t_cfg_idx;

    typedef struct packed {
        logic               filter_enable;
        logic [CUT_W-1:0]   cutoff_coeff;
        logic [RES_W-1:0]   resonance_coeff;
        logic [ROUTE_W-1:0] route_mask;
        logic               voice3_mute;
        logic [MODE_W-1:0]  mode_select;
        logic [VOL_W-1:0]   volume;
        logic [OFS_W-1:0]   mixer_offset;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_CHECK,
        S_WDT,
        S_DELTA,
        S_UPD,
        S_RESO,
        S_MIX,
        S_VSTART,
        S_VOL,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

[rtl/core/sc_svf_cfg.sv]
// Configuration register file of the filter.
`default_nettype none
module sc_svf_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr,
    input  sc_svf_pkg::t_cfg_idx                i_index,
    input  logic [sc_svf_pkg::CFG_DATA_W-1:0]   i_data,
    output sc_svf_pkg::t_cfg                    o_cfg
);
    import sc_svf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_enable   <= 1'b1;
            r_cfg.cutoff_coeff    <= '0;
            r_cfg.resonance_coeff <= RES_RESET;
            r_cfg.route_mask      <= '0;
            r_cfg.voice3_mute     <= 1'b0;
            r_cfg.mode_select     <= '0;
            r_cfg.volume          <= '0;
            r_cfg.mixer_offset    <= '0;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_FILTER_ENABLE: r_cfg.filter_enable   <= i_data[0];
                CFG_CUTOFF:        r_cfg.cutoff_coeff    <= i_data[CUT_W-1:0];
                CFG_RESONANCE:     r_cfg.resonance_coeff <= i_data[RES_W-1:0];
                CFG_ROUTE:         r_cfg.route_mask      <= i_data[ROUTE_W-1:0];
                CFG_MUTE:          r_cfg.voice3_mute     <= i_data[0];
                CFG_MODE:          r_cfg.mode_select     <= i_data[MODE_W-1:0];
                CFG_VOLUME:        r_cfg.volume          <= i_data[VOL_W-1:0];
                CFG_OFFSET:        r_cfg.mixer_offset    <= i_data[OFS_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[rtl/core/sc_svf_smul.sv]
// Serial-parallel multiplier taking one multiplier bit per cycle, low word kept.
`default_nettype none
module sc_svf_smul #(
    parameter int MB_W = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [sc_svf_pkg::DATA_W-1:0]   i_a,
    input  logic [MB_W-1:0]                 i_b,
    output logic                            o_done,
    output logic [sc_svf_pkg::DATA_W-1:0]   o_prod
);
    import sc_svf_pkg::*;

    localparam int CNT_W = (MB_W > 1) ? $clog2(MB_W) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MB_W - 1);

    logic              r_run;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_a;
    logic [MB_W-1:0]   r_b;
    logic [DATA_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_run && (r_cnt == '0);
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_LAST;
            end else if (r_run) begin
                if (r_cnt == '0) begin
                    r_run <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_run) begin
            r_acc <= r_acc + (r_b[0] ? r_a : '0);
            r_a   <= r_a << 1;
            r_b   <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

[rtl/core/sound_chip_state_variable_filter.sv]
// Each accepted word is summed, run through n filter substeps, mixed and scaled by the volume,
// where n = ceil(cycle_count / SUBSTEP_CYCLES), or zero when the filter is off.
// Words are taken one at a time: the next is accepted once the previous result is loaded,
// so the next word is taken while a finished result still waits.
// Synchronous active-low reset restores the register defaults and zeroes the filter state.
`default_nettype none
`include "sound_chip_state_variable_filter_defines.svh"
module sound_chip_state_variable_filter #(
    parameter int SUBSTEP_CYCLES = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  logic [sc_svf_pkg::CYC_W-1:0]              i_cycle_count,
    input  logic signed [sc_svf_pkg::SAMPLE_W-1:0]    i_voice_one,
    input  logic signed [sc_svf_pkg::SAMPLE_W-1:0]    i_voice_two,
    input  logic signed [sc_svf_pkg::SAMPLE_W-1:0]    i_voice_three,
    input  logic signed [sc_svf_pkg::SAMPLE_W-1:0]    i_external_in,
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output logic signed [sc_svf_pkg::DATA_W-1:0]      o_audio_out,
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  sc_svf_pkg::t_cfg_idx                      i_cfg_index,
    input  logic [sc_svf_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import sc_svf_pkg::*;

    localparam int DT_W  = $clog2(SUBSTEP_CYCLES + 1);
    localparam int WDT_W = CUT_W + DT_W - WDT_SHIFT;
    localparam logic [CYC_W-1:0] SUB_MAX = CYC_W'(SUBSTEP_CYCLES);
    localparam logic [DT_W-1:0]  SUB_DT  = DT_W'(SUBSTEP_CYCLES);

    t_cfg   w_cfg;
    t_state r_state;
    t_state n_state;

    logic w_accept;
    logic w_out_load;
    logic w_start_w;
    logic w_start_d;
    logic w_start_q;
    logic w_start_v;

    logic [CYC_W-1:0]           r_cyc;
    logic [DT_W-1:0]            r_dt;
    logic [DT_W-1:0]            w_dt;
    logic signed [SAMPLE_W-1:0] r_src [N_SRC];
    logic [1:0]                 r_k;
    logic [ROUTE_W-1:0]         r_fmask;
    logic                       r_mute;
    logic signed [SUM_W-1:0]    r_vi;
    logic signed [SUM_W-1:0]    r_bypass;
    logic signed [SUM_W-1:0]    w_src_term;
    logic [DATA_W-1:0]          r_hp;
    logic [DATA_W-1:0]          r_bp;
    logic [DATA_W-1:0]          r_lp;
    logic [DATA_W-1:0]          r_mix;
    logic                       r_out_valid;
    logic [DATA_W-1:0]          r_out;

    logic              w_w_done;
    logic              w_hp_done;
    logic              w_bp_done;
    logic              w_q_done;
    logic              w_v_done;
    logic [DATA_W-1:0] w_w_prod;
    logic [DATA_W-1:0] w_hp_prod;
    logic [DATA_W-1:0] w_bp_prod;
    logic [DATA_W-1:0] w_q_prod;
    logic [DATA_W-1:0] w_v_prod;
    logic [WDT_W-1:0]  w_wdt;
    logic signed [DATA_W-1:0] w_dbp;
    logic signed [DATA_W-1:0] w_dlp;
    logic signed [DATA_W-1:0] w_qterm;

    sc_svf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    assign w_wdt = w_w_prod[WDT_SHIFT +: WDT_W];

    sc_svf_smul #(.MB_W(DT_W)) u_mul_wdt (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_start_w),
        .i_a (DATA_W'(w_cfg.cutoff_coeff)), .i_b (w_dt),
        .o_done (w_w_done), .o_prod (w_w_prod)
    );

    sc_svf_smul #(.MB_W(WDT_W)) u_mul_hp (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_start_d),
        .i_a (r_hp), .i_b (w_wdt),
        .o_done (w_hp_done), .o_prod (w_hp_prod)
    );

    sc_svf_smul #(.MB_W(WDT_W)) u_mul_bp (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_start_d),
        .i_a (r_bp), .i_b (w_wdt),
        .o_done (w_bp_done), .o_prod (w_bp_prod)
    );

    sc_svf_smul #(.MB_W(RES_W)) u_mul_reso (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_start_q),
        .i_a (r_bp), .i_b (w_cfg.resonance_coeff),
        .o_done (w_q_done), .o_prod (w_q_prod)
    );

    sc_svf_smul #(.MB_W(VOL_W)) u_mul_vol (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_start_v),
        .i_a (r_mix), .i_b (w_cfg.volume),
        .o_done (w_v_done), .o_prod (w_v_prod)
    );

    assign w_dt    = (r_cyc < SUB_MAX) ? r_cyc[DT_W-1:0] : SUB_DT;
    assign w_dbp   = $signed(w_hp_prod) >>> BP_SHIFT;
    assign w_dlp   = $signed(w_bp_prod) >>> BP_SHIFT;
    assign w_qterm = $signed(w_q_prod) >>> Q_SHIFT;
    assign w_src_term = (r_k == VOICE3_SLOT && r_mute) ? '0 : SUM_W'(r_src[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        w_accept   = 1'b0;
        w_out_load = 1'b0;
        w_start_w  = 1'b0;
        w_start_d  = 1'b0;
        w_start_q  = 1'b0;
        w_start_v  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    w_accept = 1'b1;
                    n_state  = S_SUM;
                end
            end
            S_SUM: begin
                if (r_k == LAST_SLOT) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!w_cfg.filter_enable || r_cyc == '0) begin
                    n_state = S_MIX;
                end else begin
                    w_start_w = 1'b1;
                    n_state   = S_WDT;
                end
            end
            S_WDT: begin
                if (w_w_done) begin
                    w_start_d = 1'b1;
                    n_state   = S_DELTA;
                end
            end
            S_DELTA: begin
                if (w_hp_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                w_start_q = 1'b1;
                n_state   = S_RESO;
            end
            S_RESO: begin
                if (w_q_done) begin
                    n_state = S_CHECK;
                end
            end
            S_MIX: begin
                if (r_k == LAST_SLOT) begin
                    n_state = S_VSTART;
                end
            end
            S_VSTART: begin
                w_start_v = 1'b1;
                n_state   = S_VOL;
            end
            S_VOL: begin
                if (w_v_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp        <= '0;
            r_bp        <= '0;
            r_lp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_SUM && r_k == LAST_SLOT && !w_cfg.filter_enable) begin
                r_hp <= '0;
                r_bp <= '0;
                r_lp <= '0;
            end
            if (r_state == S_DELTA && w_hp_done) begin
                r_bp <= r_bp - w_dbp;
                r_lp <= r_lp - w_dlp;
            end
            if (r_state == S_RESO && w_q_done) begin
                r_hp <= w_qterm - r_lp - DATA_W'(r_vi);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cyc    <= i_cycle_count;
            r_src[0] <= i_voice_one;
            r_src[1] <= i_voice_two;
            r_src[2] <= i_voice_three;
            r_src[3] <= i_external_in;
            r_k      <= '0;
            r_fmask  <= w_cfg.filter_enable ? w_cfg.route_mask : '0;
            r_mute   <= w_cfg.voice3_mute && !w_cfg.route_mask[VOICE3_SLOT];
            r_vi     <= '0;
            r_bypass <= '0;
        end
        if (r_state == S_SUM) begin
            if (r_fmask[r_k]) begin
                r_vi <= r_vi + w_src_term;
            end else begin
                r_bypass <= r_bypass + w_src_term;
            end
            for (int i = 0; i < N_SRC - 1; i++) begin
                r_src[i] <= r_src[i + 1];
            end
            r_k <= r_k + 1'b1;
        end
        if (w_start_w) begin
            r_dt <= w_dt;
        end
        if (r_state == S_RESO && w_q_done) begin
            r_cyc <= r_cyc - CYC_W'(r_dt);
        end
        if (r_state == S_MIX) begin
            unique case (r_k)
                2'd0: r_mix <= DATA_W'(r_bypass) + DATA_W'($signed(w_cfg.mixer_offset));
                2'd1: r_mix <= r_mix + (w_cfg.mode_select[MODE_LP] ? r_lp : '0);
                2'd2: r_mix <= r_mix + (w_cfg.mode_select[MODE_BP] ? r_bp : '0);
                2'd3: r_mix <= r_mix + (w_cfg.mode_select[MODE_HP] ? r_hp : '0);
            endcase
            r_k <= r_k + 1'b1;
        end
        if (w_out_load) begin
            r_out <= w_v_prod;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_audio_out = r_out;
    assign o_cfg_ready = 1'b1;

    `SC_SVF_ASSERT_IMPLIES(a_bypass_clears_levels, i_clk, i_rst_n,
        (r_state == S_MIX) && !w_cfg.filter_enable,
        (r_hp == '0) && (r_bp == '0) && (r_lp == '0))
    `SC_SVF_ASSERT_IMPLIES(a_substep_in_range, i_clk, i_rst_n,
        (r_state == S_RESO),
        (r_dt != '0) && (CYC_W'(r_dt) <= r_cyc))
    `SC_SVF_ASSERT_IMPLIES(a_delta_lanes_in_step, i_clk, i_rst_n,
        1'b1, w_hp_done == w_bp_done)
    `SC_SVF_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n,
        w_out_load, o_out_valid && (r_state == S_IDLE))

endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking bench for the sound chip state variable filter with mixer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sc_svf_pkg::*;

    localparam int          SUBSTEP_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT    = 6_000_000;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 20'sh7FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 20'sh80000;

    typedef struct packed {
        logic [CYC_W-1:0]           cycle_count;
        logic signed [SAMPLE_W-1:0] voice_one;
        logic signed [SAMPLE_W-1:0] voice_two;
        logic signed [SAMPLE_W-1:0] voice_three;
        logic signed [SAMPLE_W-1:0] external_in;
    } t_mixer_word;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_audio_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index = CFG_FILTER_ENABLE;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    t_mixer_word           held_word   = '0;

    // Predictor copy of the register file and of the filter integrators.
    t_cfg                  model_cfg;
    logic [DATA_W-1:0]     hp_level = '0;
    logic [DATA_W-1:0]     bp_level = '0;
    logic [DATA_W-1:0]     lp_level = '0;

    t_mixer_word           pending_words [$];
    logic [DATA_W-1:0]     audio_due [$];

    int unsigned mismatches      = 0;
    int unsigned words_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned settings_seen   = 0;
    int unsigned cycles_run      = 0;
    int          burst_left      = 0;
    int          gap_left        = 0;
    int          stall_run_left  = 0;
    bit          stalling        = 1'b0;

    sound_chip_state_variable_filter #(
        .SUBSTEP_CYCLES(SUBSTEP_CYCLES)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cycle_count(held_word.cycle_count),
        .i_voice_one  (held_word.voice_one),
        .i_voice_two  (held_word.voice_two),
        .i_voice_three(held_word.voice_three),
        .i_external_in(held_word.external_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_audio_out  (o_audio_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [DATA_W-1:0] filter_mix(input t_mixer_word w);
        logic [DATA_W-1:0] src [N_SRC];
        logic [DATA_W-1:0] to_filter;
        logic [DATA_W-1:0] bypass;
        logic [DATA_W-1:0] picked;
        logic [DATA_W-1:0] offset;
        logic [DATA_W-1:0] cut;
        logic [DATA_W-1:0] res_q;
        logic [DATA_W-1:0] wdt;
        logic [DATA_W-1:0] dbp;
        logic [DATA_W-1:0] dlp;
        logic [DATA_W-1:0] damped;
        int unsigned       left;
        int unsigned       dt;
        src[0]    = DATA_W'(w.voice_one);
        src[1]    = DATA_W'(w.voice_two);
        src[2]    = DATA_W'(w.voice_three);
        src[3]    = DATA_W'(w.external_in);
        offset    = DATA_W'($signed(model_cfg.mixer_offset));
        cut       = DATA_W'(model_cfg.cutoff_coeff);
        res_q     = DATA_W'(model_cfg.resonance_coeff);
        left      = 32'(w.cycle_count);
        to_filter = '0;
        bypass    = '0;
        picked    = '0;
        if (model_cfg.voice3_mute && !model_cfg.route_mask[VOICE3_SLOT]) begin
            src[VOICE3_SLOT] = '0;
        end
        if (!model_cfg.filter_enable) begin
            hp_level = '0;
            bp_level = '0;
            lp_level = '0;
            return (src[0] + src[1] + src[2] + src[3] + offset) * DATA_W'(model_cfg.volume);
        end
        for (int k = 0; k < N_SRC; k++) begin
            if (model_cfg.route_mask[k]) begin
                to_filter += src[k];
            end else begin
                bypass += src[k];
            end
        end
        while (left != 0) begin
            dt       = (left < SUBSTEP_CYCLES) ? left : SUBSTEP_CYCLES;
            wdt      = (cut * dt) >> WDT_SHIFT;
            dbp      = $signed(wdt * hp_level) >>> BP_SHIFT;
            dlp      = $signed(wdt * bp_level) >>> BP_SHIFT;
            bp_level = bp_level - dbp;
            lp_level = lp_level - dlp;
            damped   = $signed(bp_level * res_q) >>> Q_SHIFT;
            hp_level = damped - lp_level - to_filter;
            left     = left - dt;
        end
        if (model_cfg.mode_select[MODE_LP]) begin
            picked += lp_level;
        end
        if (model_cfg.mode_select[MODE_BP]) begin
            picked += bp_level;
        end
        if (model_cfg.mode_select[MODE_HP]) begin
            picked += hp_level;
        end
        return (bypass + picked + offset) * DATA_W'(model_cfg.volume);
    endfunction

    // Sender: words leave the queue in bursts separated by idle gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                audio_due.push_back(filter_mix(held_word));
                words_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    held_word  <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 :
                                     $urandom_range(1, ($urandom_range(0, 4) == 0) ? 120 : 12);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted word and stalls in runs of random length.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (audio_due.size() == 0) begin
                    $display("%0t: audio_out %0d arrived with no result expected",
                             $time, o_audio_out);
                    mismatches++;
                end else begin
                    if (o_audio_out !== audio_due[0]) begin
                        $display("%0t: audio_out expected %0d, got %0d", $time,
                                 $signed(audio_due[0]), o_audio_out);
                        mismatches++;
                    end
                    void'(audio_due.pop_front());
                    results_checked++;
                end
            end
            if (stall_run_left == 0) begin
                stalling       = !stalling;
                stall_run_left = stalling ? $urandom_range(1, 24) :
                                 ($urandom_range(0, 3) == 0) ? $urandom_range(100, 600) :
                                 $urandom_range(1, 12);
            end else begin
                stall_run_left--;
            end
            i_out_stall <= stalling;
        end
    end

    always @(posedge i_clk) begin
        cycles_run++;
        if (cycles_run >= CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles, %0d results still awaited",
                     $time, cycles_run, audio_due.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_FILTER_ENABLE: model_cfg.filter_enable   = data[0];
            CFG_CUTOFF:        model_cfg.cutoff_coeff    = data[CUT_W-1:0];
            CFG_RESONANCE:     model_cfg.resonance_coeff = data[RES_W-1:0];
            CFG_ROUTE:         model_cfg.route_mask      = data[ROUTE_W-1:0];
            CFG_MUTE:          model_cfg.voice3_mute     = data[0];
            CFG_MODE:          model_cfg.mode_select     = data[MODE_W-1:0];
            CFG_VOLUME:        model_cfg.volume          = data[VOL_W-1:0];
            CFG_OFFSET:        model_cfg.mixer_offset    = data[OFS_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [CFG_DATA_W-1:0] noisy(input int unsigned value,
                                                     input int unsigned w);
        logic [CFG_DATA_W-1:0] keep;
        keep = CFG_DATA_W'((32'd1 << w) - 1);
        if ($urandom_range(0, 2) == 0) begin
            return (CFG_DATA_W'($urandom) & ~keep) | (CFG_DATA_W'(value) & keep);
        end
        return CFG_DATA_W'(value) & keep;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic t_mixer_word random_word();
        t_mixer_word w;
        int unsigned pick;
        pick          = $urandom_range(0, 19);
        w.cycle_count = CYC_W'((pick < 2) ? 0 : (pick < 5) ? $urandom_range(0, 255) :
                               $urandom_range(1, 24));
        w.voice_one   = random_sample();
        w.voice_two   = random_sample();
        w.voice_three = random_sample();
        w.external_in = random_sample();
        return w;
    endfunction

    task automatic queue_word(input int unsigned cyc, input logic signed [SAMPLE_W-1:0] v1,
                              input logic signed [SAMPLE_W-1:0] v2,
                              input logic signed [SAMPLE_W-1:0] v3,
                              input logic signed [SAMPLE_W-1:0] ext);
        t_mixer_word w;
        w.cycle_count = CYC_W'(cyc);
        w.voice_one   = v1;
        w.voice_two   = v2;
        w.voice_three = v3;
        w.external_in = ext;
        pending_words.push_back(w);
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || i_in_valid || audio_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_setting(input int ph);
        int unsigned cutoff;
        int unsigned reso;
        int unsigned vol;
        int          offset;
        case (ph)
            0: begin
                cutoff = 26353;
                reso   = 1448;
                vol    = 15;
                offset = 0;
            end
            1: begin
                cutoff = 0;
                reso   = 599;
                vol    = 1;
                offset = -454;
            end
            default: begin
                case ($urandom_range(0, 4))
                    0:       cutoff = $urandom_range(0, 32767);
                    1:       cutoff = 26353;
                    default: cutoff = $urandom_range(0, 26353);
                endcase
                case ($urandom_range(0, 5))
                    0:       reso = $urandom_range(0, 2047);
                    1:       reso = 599;
                    2:       reso = 1448;
                    default: reso = $urandom_range(599, 1448);
                endcase
                vol    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 15);
                offset = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 1023)) - 512 :
                         -int'($urandom_range(0, 454));
            end
        endcase
        write_reg(CFG_FILTER_ENABLE,
                  noisy((ph == 3) ? 0 : ($urandom_range(0, 5) != 0), 1));
        write_reg(CFG_CUTOFF, noisy(cutoff, CUT_W));
        write_reg(CFG_RESONANCE, noisy(reso, RES_W));
        write_reg(CFG_ROUTE, noisy($urandom_range(0, 15), ROUTE_W));
        write_reg(CFG_MUTE, noisy($urandom_range(0, 1), 1));
        write_reg(CFG_MODE, noisy($urandom_range(0, 7), MODE_W));
        write_reg(CFG_VOLUME, noisy(vol, VOL_W));
        write_reg(CFG_OFFSET, noisy(offset, OFS_W));
        settings_seen++;
    endtask

    initial begin
        model_cfg                 = '0;
        model_cfg.filter_enable   = 1'b1;
        model_cfg.resonance_coeff = RES_RESET;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: sample and cycle count extremes with all three outputs mixed.
        write_reg(CFG_CUTOFF, 15'd26353);
        write_reg(CFG_RESONANCE, 15'd599);
        write_reg(CFG_ROUTE, 15'b0101);
        write_reg(CFG_MUTE, 15'd1);
        write_reg(CFG_MODE, 15'd7);
        write_reg(CFG_VOLUME, 15'd15);
        write_reg(CFG_OFFSET, 15'h3FF & 15'(-454));
        settings_seen++;
        @(negedge i_clk);
        queue_word(0, 0, 0, 0, 0);
        queue_word(0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        queue_word(0, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
        queue_word(1, SAMPLE_MAX, 0, 0, 0);
        queue_word(7, SAMPLE_MIN, 0, 0, 0);
        queue_word(8, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
        queue_word(9, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        queue_word(255, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        queue_word(255, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
        queue_word(16, 20'sd1234, -20'sd4321, 20'sd77, -20'sd1);
        drain();

        // Voice 3 muted because it bypasses the filter; lowpass only.
        write_reg(CFG_ROUTE, 15'b1011);
        write_reg(CFG_MODE, 15'd1);
        write_reg(CFG_OFFSET, 15'd511);
        settings_seen++;
        @(negedge i_clk);
        queue_word(8, 20'sd1000, 20'sd2000, SAMPLE_MAX, 20'sd3000);
        queue_word(24, -20'sd500, 20'sd0, SAMPLE_MIN, 20'sd100);
        queue_word(0, 20'sd1, 20'sd2, SAMPLE_MAX, 20'sd4);
        drain();

        // Mute set but voice 3 routed to the filter; bandpass, highpass, then nothing.
        write_reg(CFG_ROUTE, 15'b1111);
        write_reg(CFG_MODE, 15'd2);
        settings_seen++;
        @(negedge i_clk);
        queue_word(40, SAMPLE_MAX, 20'sd0, SAMPLE_MAX, 20'sd0);
        queue_word(3, 20'sd0, SAMPLE_MIN, SAMPLE_MIN, 20'sd0);
        drain();
        write_reg(CFG_MODE, 15'd4);
        settings_seen++;
        @(negedge i_clk);
        queue_word(17, SAMPLE_MAX, SAMPLE_MAX, 20'sd0, SAMPLE_MIN);
        queue_word(64, 20'sd0, 20'sd0, 20'sd0, 20'sd0);
        drain();
        write_reg(CFG_MODE, 15'd0);
        settings_seen++;
        @(negedge i_clk);
        queue_word(12, SAMPLE_MIN, 20'sd5, SAMPLE_MAX, 20'sd9);
        drain();

        // Filter off: state clears and only the bypass path is heard.
        write_reg(CFG_FILTER_ENABLE, 15'd0);
        write_reg(CFG_ROUTE, 15'd0);
        write_reg(CFG_MODE, 15'd7);
        settings_seen++;
        @(negedge i_clk);
        queue_word(255, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        queue_word(0, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
        drain();
        write_reg(CFG_MUTE, 15'd0);
        settings_seen++;
        @(negedge i_clk);
        queue_word(5, SAMPLE_MIN, 20'sd10, SAMPLE_MIN, SAMPLE_MAX);
        drain();

        // Filter back on with coefficients beyond their usual range.
        write_reg(CFG_FILTER_ENABLE, 15'd1);
        write_reg(CFG_CUTOFF, 15'h7FFF);
        write_reg(CFG_RESONANCE, 15'h7FF);
        write_reg(CFG_ROUTE, 15'b0110);
        settings_seen++;
        @(negedge i_clk);
        queue_word(255, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
        queue_word(200, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        drain();
        write_reg(CFG_CUTOFF, 15'd0);
        write_reg(CFG_RESONANCE, 15'd0);
        settings_seen++;
        @(negedge i_clk);
        queue_word(33, 20'sd7, SAMPLE_MAX, 20'sd0, SAMPLE_MIN);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            random_setting(ph);
            @(negedge i_clk);
            repeat (70) pending_words.push_back(random_word());
            drain();
        end

        repeat (60) @(posedge i_clk);
        $display("Checked %0d mixer results from %0d sample words under %0d register settings.",
                 results_checked, words_sent, settings_seen);
        $display("Settings spanned filter on and off, every mode and route, and edge coefficients.");
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
